// ----- rtl/dbpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared types and constants of the point clustering block.
// ----------------------------------------------------------------------------
package dbpc_pkg;

  localparam int EPS_W      = 16;
  localparam int MINN_W     = 11;
  localparam int LABEL_W    = 12;
  localparam int TOTAL_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int IN_COORD_W = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_POINT = 2'd2;

  // register select is byte address bit 2
  localparam logic REG_EPS  = 1'b0;
  localparam logic REG_MINN = 1'b1;

  localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd50;
  localparam logic [MINN_W-1:0]  MINN_RESET  = 11'd5;
  localparam logic [LABEL_W-1:0] LABEL_NOISE = '1;

  typedef struct packed {
    logic [1:0]                    op;
    logic signed [IN_COORD_W-1:0]  x_coord;
    logic signed [IN_COORD_W-1:0]  y_coord;
    logic signed [IN_COORD_W-1:0]  z_coord;
    logic [INDEX_W-1:0]            index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [LABEL_W-1:0]  label;
    logic [TOTAL_W-1:0]         cluster_total;
    logic [TOTAL_W-1:0]         point_total;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic far;
  } link_ctl_t;

endpackage

// ----- rtl/dbpc_axis_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpc_axis_cell
// One axis of the distance test: abs difference and radius check, then
// square and add into the running sum. Two register stages.
// ----------------------------------------------------------------------------
module dbpc_axis_cell #(
  parameter int COORD_BITS = 16,
  parameter int AW         = 10,
  parameter int SW         = 34,
  parameter int AXIS       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbpc_pkg::link_ctl_t           ctl_i,
  input  logic [AW-1:0]                 idx_i,
  input  logic [3*COORD_BITS-1:0]       pt_i,
  input  logic [SW-1:0]                 sum_i,
  input  logic signed [COORD_BITS-1:0]  a_i,
  input  logic [dbpc_pkg::EPS_W-1:0]    eps_i,
  output dbpc_pkg::link_ctl_t           ctl_o,
  output logic [AW-1:0]                 idx_o,
  output logic [3*COORD_BITS-1:0]       pt_o,
  output logic [SW-1:0]                 sum_o,
  output logic                          busy_o
);
  import dbpc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int MW = (DW > EPS_W) ? DW : EPS_W;

  logic signed [DW-1:0]     a_e, b_e, d;
  logic [MW-1:0]            d_m;
  link_ctl_t                ctl_a_nxt;

  link_ctl_t                ctl_a_r, ctl_b_r;
  logic [AW-1:0]            idx_a_r, idx_b_r;
  logic [3*COORD_BITS-1:0]  pt_a_r, pt_b_r;
  logic [SW-1:0]            sum_a_r, sum_b_r;
  logic [EPS_W-1:0]         dm_a_r;
  logic [2*EPS_W-1:0]       sq;

  always_comb begin
    a_e = {a_i[COORD_BITS-1], a_i};
    b_e = {pt_i[AXIS*COORD_BITS+COORD_BITS-1], pt_i[AXIS*COORD_BITS +: COORD_BITS]};
    d   = (a_e >= b_e) ? (a_e - b_e) : (b_e - a_e);
    d_m = MW'($unsigned(d));
    ctl_a_nxt.vld = ctl_i.vld;
    ctl_a_nxt.far = ctl_i.far | (d_m > MW'(eps_i));
    sq  = dm_a_r * dm_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
    end
    idx_a_r <= idx_i;
    pt_a_r  <= pt_i;
    sum_a_r <= sum_i;
    // past the radius the square is never used, so keep the low bits only
    dm_a_r  <= d_m[EPS_W-1:0];
    idx_b_r <= idx_a_r;
    pt_b_r  <= pt_a_r;
    sum_b_r <= sum_a_r + SW'(sq);
  end

  assign ctl_o  = ctl_b_r;
  assign idx_o  = idx_b_r;
  assign pt_o   = pt_b_r;
  assign sum_o  = sum_b_r;
  assign busy_o = ctl_a_r.vld | ctl_b_r.vld;

endmodule

// ----- rtl/dbpc_near_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpc_near_chain
// Row of three axis cells and a final radius compare. Takes one swept
// point per cycle; its neighbor flag comes out of a result register.
// ----------------------------------------------------------------------------
module dbpc_near_chain #(
  parameter int COORD_BITS = 16,
  parameter int AW         = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue_vld,
  input  logic [AW-1:0]                 issue_idx,
  input  logic [3*COORD_BITS-1:0]       pt_q,
  input  logic [3*COORD_BITS-1:0]       pc,
  input  logic [dbpc_pkg::EPS_W-1:0]    eps,
  input  logic [2*dbpc_pkg::EPS_W-1:0]  eps_sq,
  output logic [AW-1:0]                 tap_idx,
  output logic                          res_vld,
  output logic                          res_near,
  output logic [AW-1:0]                 res_idx,
  output logic                          busy
);
  import dbpc_pkg::*;

  localparam int SW = 2*EPS_W + 2;

  logic                     v_m_r;
  logic [AW-1:0]            idx_m_r;
  link_ctl_t                ctl_w [0:3];
  logic [AW-1:0]            idx_w [0:3];
  logic [3*COORD_BITS-1:0]  pt_w  [0:3];
  logic [SW-1:0]            sum_w [0:3];
  logic [2:0]               cell_busy;
  logic                     res_vld_r, res_near_r;
  logic [AW-1:0]            res_idx_r;

  assign ctl_w[0].vld = v_m_r;
  assign ctl_w[0].far = 1'b0;
  assign idx_w[0]     = idx_m_r;
  assign pt_w[0]      = pt_q;
  assign sum_w[0]     = '0;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    dbpc_axis_cell #(
      .COORD_BITS(COORD_BITS), .AW(AW), .SW(SW), .AXIS(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_w[k]),
      .idx_i  (idx_w[k]),
      .pt_i   (pt_w[k]),
      .sum_i  (sum_w[k]),
      .a_i    (pc[k*COORD_BITS +: COORD_BITS]),
      .eps_i  (eps),
      .ctl_o  (ctl_w[k+1]),
      .idx_o  (idx_w[k+1]),
      .pt_o   (pt_w[k+1]),
      .sum_o  (sum_w[k+1]),
      .busy_o (cell_busy[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      v_m_r     <= issue_vld;
      res_vld_r <= ctl_w[3].vld;
    end
    idx_m_r    <= issue_idx;
    res_idx_r  <= idx_w[3];
    res_near_r <= !ctl_w[3].far && (sum_w[3] <= SW'(eps_sq));
  end

  assign tap_idx  = idx_w[3];
  assign res_vld  = res_vld_r;
  assign res_near = res_near_r;
  assign res_idx  = res_idx_r;
  assign busy     = v_m_r | (|cell_busy) | res_vld_r;

endmodule

// ----- rtl/dbscan_point_clustering_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbscan_point_clustering_top
// Brute-force density clustering over a loaded point store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in_     | input     | in_valid / in_stall    | in_data   (op, coords, index)
//  out_    | output    | out_valid / out_stall  | out_data  (status, label, totals)
//  cfg     | input     | psel/penable/pwrite    | eps_radius @0, min_neighbors @4
//
//  Load and clear answer from idle; a read waits in S_RDW on the label RAM.
//  A run first clears the visited flags and labels, then for each neighbor
//  sweep streams every loaded point through the distance cell row, plus
//  the queue and flag accesses for each point that is taken up.
//  Reset is synchronous; the point store is not cleared. A stall on the
//  output holds the result word and blocks further input.
// ----------------------------------------------------------------------------
module dbscan_point_clustering_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dbpc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dbpc_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dbpc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 3*COORD_BITS;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RDW    = 11'b000_0000_0010,
    S_CLR    = 11'b000_0000_0100,
    S_OUTER  = 11'b000_0000_1000,
    S_OTEST  = 11'b000_0001_0000,
    S_PFETCH = 11'b000_0010_0000,
    S_PLOAD  = 11'b000_0100_0000,
    S_SCAN   = 11'b000_1000_0000,
    S_DRAIN  = 11'b001_0000_0000,
    S_QPOP   = 11'b010_0000_0000,
    S_QGET   = 11'b100_0000_0000
  } state_t;

  // memories
  logic [PW-1:0]      pt_mem  [MAX_POINTS];
  logic [LABEL_W-1:0] lab_mem [MAX_POINTS];
  logic               vis_mem [MAX_POINTS];
  logic [AW-1:0]      q_mem   [MAX_POINTS];

  logic               pt_we, lab_we, vis_we, q_we, vis_wd;
  logic [AW-1:0]      pt_waddr, pt_raddr, lab_waddr, lab_raddr;
  logic [AW-1:0]      vis_waddr, vis_raddr, q_waddr, q_raddr;
  logic [PW-1:0]      pt_wd, pt_q;
  logic [LABEL_W-1:0] lab_wd, lab_q;
  logic [AW-1:0]      q_wd, q_q;
  logic               vis_q;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      loaded_r, loaded_nxt, labeled_r, labeled_nxt;
  logic [CW-1:0]      cluster_r, cluster_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]      cid_r, cid_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0]      p_r, p_nxt;
  logic               seed_r, seed_nxt, upd_r, upd_nxt;
  logic               rd_hit_r, rd_hit_nxt, rd_lab_r, rd_lab_nxt;
  logic [PW-1:0]      pc_r, pc_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;
  logic [EPS_W-1:0]   eps_r;
  logic [MINN_W-1:0]  minn_r;
  logic [2*EPS_W-1:0] eps_sq_r;

  logic               accept, cfg_wr, scan_issue, below_min;
  logic [CW-1:0]      cid_inc;
  logic [AW-1:0]      tap_idx, res_idx;
  logic               res_vld, res_near, chain_busy;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MINN) ? 32'(minn_r) : 32'(eps_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RESET;
      minn_r <= MINN_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_EPS) eps_r <= pwdata[EPS_W-1:0];
      else                     minn_r <= pwdata[MINN_W-1:0];
    end
    eps_sq_r <= eps_r * eps_r;
  end

  dbpc_near_chain #(.COORD_BITS(COORD_BITS), .AW(AW)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_vld (scan_issue),
    .issue_idx (j_r[AW-1:0]),
    .pt_q      (pt_q),
    .pc        (pc_r),
    .eps       (eps_r),
    .eps_sq    (eps_sq_r),
    .tap_idx   (tap_idx),
    .res_vld   (res_vld),
    .res_near  (res_near),
    .res_idx   (res_idx),
    .busy      (chain_busy)
  );

  always_ff @(posedge clk) begin
    if (pt_we)  pt_mem[pt_waddr]   <= pt_wd;
    if (lab_we) lab_mem[lab_waddr] <= lab_wd;
    if (vis_we) vis_mem[vis_waddr] <= vis_wd;
    if (q_we)   q_mem[q_waddr]     <= q_wd;
    pt_q  <= pt_mem[pt_raddr];
    lab_q <= lab_mem[lab_raddr];
    vis_q <= vis_mem[vis_raddr];
    q_q   <= q_mem[q_raddr];
  end

  assign scan_issue = (state_r == S_SCAN);
  assign below_min  = 32'(cnt_r) < 32'(minn_r);
  assign cid_inc    = cid_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    loaded_nxt  = loaded_r;
    labeled_nxt = labeled_r;
    cluster_nxt = cluster_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cid_nxt     = cid_r;
    cnt_nxt     = cnt_r;
    p_nxt       = p_r;
    seed_nxt    = seed_r;
    upd_nxt     = upd_r;
    rd_hit_nxt  = rd_hit_r;
    rd_lab_nxt  = rd_lab_r;
    pc_nxt      = pc_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    pt_we = 1'b0;  pt_waddr = loaded_r[AW-1:0];
    pt_wd = {COORD_BITS'($unsigned(in_data.x_coord)),
             COORD_BITS'($unsigned(in_data.y_coord)),
             COORD_BITS'($unsigned(in_data.z_coord))};
    pt_raddr = (state_r == S_SCAN) ? j_r[AW-1:0] : p_r;
    lab_we = 1'b0;  lab_waddr = res_idx;  lab_wd = LABEL_W'(cid_r);
    lab_raddr = (state_r == S_IDLE) ? AW'(in_data.index) : tap_idx;
    vis_we = 1'b0;  vis_waddr = res_idx;  vis_wd = 1'b1;
    vis_raddr = (state_r == S_OUTER) ? i_r[AW-1:0] : tap_idx;
    q_we = 1'b0;  q_waddr = tail_r[AW-1:0];  q_wd = res_idx;
    q_raddr = head_r[AW-1:0];

    // neighbor sweep: count neighbors, or in expansion mark and queue fresh neighbors and adopt noise points
    if (res_vld && res_near) begin
      if (upd_r) begin
        if (!vis_q) begin
          vis_we   = 1'b1;
          lab_we   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end else if (lab_q == LABEL_NOISE) begin
          lab_we = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.status        = ST_OK;
          out_nxt.label         = '0;
          out_nxt.cluster_total = TOTAL_W'(cluster_r);
          out_nxt.point_total   = TOTAL_W'(loaded_r);
          case (in_data.op)
            OP_LOAD: begin
              if (loaded_r == CW'(MAX_POINTS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                pt_we      = 1'b1;
                loaded_nxt = loaded_r + 1'b1;
                out_nxt.point_total = TOTAL_W'(loaded_r + 1'b1);
              end
              out_valid_nxt = 1'b1;
            end
            OP_RUN: begin
              j_nxt   = '0;
              i_nxt   = '0;
              cid_nxt = '0;
              state_nxt = (loaded_r == '0) ? S_OUTER : S_CLR;
            end
            OP_READ: begin
              rd_hit_nxt = 32'(in_data.index) < 32'(loaded_r);
              rd_lab_nxt = 32'(in_data.index) < 32'(labeled_r);
              state_nxt  = S_RDW;
            end
            OP_CLEAR: begin
              loaded_nxt  = '0;
              labeled_nxt = '0;
              cluster_nxt = '0;
              out_nxt.cluster_total = '0;
              out_nxt.point_total   = '0;
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RDW: begin
        out_nxt.status = rd_hit_r ? ST_OK : ST_NO_POINT;
        out_nxt.label  = (rd_hit_r && rd_lab_r) ? lab_q : '0;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_CLR: begin
        vis_we = 1'b1;  vis_waddr = j_r[AW-1:0];  vis_wd = 1'b0;
        lab_we = 1'b1;  lab_waddr = j_r[AW-1:0];  lab_wd = LABEL_NOISE;
        j_nxt = j_r + 1'b1;
        if (j_r == loaded_r - 1'b1) state_nxt = S_OUTER;
      end
      S_OUTER: begin
        if (i_r == loaded_r) begin
          cluster_nxt = cid_r;
          labeled_nxt = loaded_r;
          out_nxt.status        = ST_OK;
          out_nxt.label         = '0;
          out_nxt.cluster_total = TOTAL_W'(cid_r);
          out_nxt.point_total   = TOTAL_W'(loaded_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_OTEST;
        end
      end
      S_OTEST: begin
        if (vis_q) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else begin
          vis_we    = 1'b1;  vis_waddr = i_r[AW-1:0];
          p_nxt     = i_r[AW-1:0];
          seed_nxt  = 1'b1;
          upd_nxt   = 1'b0;
          state_nxt = S_PFETCH;
        end
      end
      S_PFETCH: state_nxt = S_PLOAD;
      S_PLOAD: begin
        pc_nxt    = pt_q;
        j_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        j_nxt = j_r + 1'b1;
        if (j_r == loaded_r - 1'b1) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!chain_busy) begin
          if (upd_r) begin
            state_nxt = S_QPOP;
          end else if (seed_r) begin
            seed_nxt = 1'b0;
            if (below_min) begin
              i_nxt     = i_r + 1'b1;
              state_nxt = S_OUTER;
            end else begin
              // new cluster seeded from this point
              cid_nxt  = cid_inc;
              lab_we   = 1'b1;  lab_waddr = i_r[AW-1:0];  lab_wd = LABEL_W'(cid_inc);
              q_we     = 1'b1;  q_waddr = '0;  q_wd = i_r[AW-1:0];
              head_nxt = '0;
              tail_nxt = CW'(1);
              state_nxt = S_QPOP;
            end
          end else if (below_min) begin
            state_nxt = S_QPOP;
          end else begin
            upd_nxt   = 1'b1;
            j_nxt     = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_QPOP: begin
        if (head_r == tail_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_QGET;
        end
      end
      S_QGET: begin
        p_nxt     = q_q;
        // the seed itself was already counted
        upd_nxt   = (q_q == i_r[AW-1:0]);
        state_nxt = S_PFETCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      labeled_r   <= '0;
      cluster_r   <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= 1'b0;
      upd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      labeled_r   <= labeled_nxt;
      cluster_r   <= cluster_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
      upd_r       <= upd_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    cid_r    <= cid_nxt;
    cnt_r    <= cnt_nxt;
    p_r      <= p_nxt;
    rd_hit_r <= rd_hit_nxt;
    rd_lab_r <= rd_lab_nxt;
    pc_r     <= pc_nxt;
    out_r    <= out_nxt;
  end

endmodule
